FILE: rtl/sparse_matrix_entry_store_top_macros.svh
// Assertion macros for the sparse matrix entry store.
// Used by sparse_matrix_entry_store_top; depends on nothing else.
`ifndef SPARSE_MATRIX_ENTRY_STORE_TOP_MACROS_SVH
`define SPARSE_MATRIX_ENTRY_STORE_TOP_MACROS_SVH

// Same-cycle implication, reset masked.
`define SMES_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smes assertion failed");

// Next-cycle implication, reset masked.
`define SMES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smes assertion failed");

`endif

FILE: rtl/smes_pkg.sv
// Shared types and codes for the sparse matrix entry store.
// Used by smes_cell, sparse_matrix_entry_store_top and the bench; no dependencies.
package smes_pkg;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic        func;
        logic [15:0] row_index;
        logic [15:0] col_index;
        logic [31:0] write_value;
    } smes_in_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic [1:0]  status;
    } smes_out_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_UPDATE,
        OP_INSERT,
        OP_DELETE
    } cell_op_t;

    typedef enum logic {
        ST_IDLE,
        ST_APPLY
    } state_t;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic     cmp_en;
        logic     apply_en;
        cell_op_t op;
    } cell_ctrl_t;

endpackage

FILE: rtl/smes_cell.sv
// One slot of the ordered entry chain: holds a (row, col, value) triple.
// Depends on smes_pkg.
module smes_cell import smes_pkg::*; #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cell_ctrl_t            ctrl,
    input  logic [INDEX_BITS-1:0] key_row,
    input  logic [INDEX_BITS-1:0] key_col,
    input  logic [31:0]           new_value,
    input  logic                  left_valid,
    input  logic [INDEX_BITS-1:0] left_row,
    input  logic [INDEX_BITS-1:0] left_col,
    input  logic [31:0]           left_value,
    input  logic                  left_lt,
    input  logic                  right_valid,
    input  logic [INDEX_BITS-1:0] right_row,
    input  logic [INDEX_BITS-1:0] right_col,
    input  logic [31:0]           right_value,
    output logic                  valid_o,
    output logic [INDEX_BITS-1:0] row_o,
    output logic [INDEX_BITS-1:0] col_o,
    output logic [31:0]           value_o,
    output logic                  lt_o,
    output logic                  eq_o
);

    logic                  valid_reg, valid_next;
    logic [INDEX_BITS-1:0] row_reg, row_next;
    logic [INDEX_BITS-1:0] col_reg, col_next;
    logic [31:0]           value_reg, value_next;
    logic                  lt_reg, lt_next;
    logic                  eq_reg, eq_next;
    logic                  at_slot;

    // Row-major key compare, unsigned.
    always_comb begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (ctrl.cmp_en) begin
            lt_next = valid_reg && ({row_reg, col_reg} < {key_row, key_col});
            eq_next = valid_reg && ({row_reg, col_reg} == {key_row, key_col});
        end
    end

    // This cell is the first one not below the key.
    assign at_slot = !lt_reg && left_lt;

    always_comb begin
        valid_next = valid_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        value_next = value_reg;
        if (ctrl.apply_en) begin
            unique case (ctrl.op)
                OP_UPDATE: begin
                    if (eq_reg) begin
                        value_next = new_value;
                    end
                end
                OP_INSERT: begin
                    if (at_slot) begin
                        valid_next = 1'b1;
                        row_next   = key_row;
                        col_next   = key_col;
                        value_next = new_value;
                    end else if (!lt_reg) begin
                        valid_next = left_valid;
                        row_next   = left_row;
                        col_next   = left_col;
                        value_next = left_value;
                    end
                end
                OP_DELETE: begin
                    if (!lt_reg) begin
                        valid_next = right_valid;
                        row_next   = right_row;
                        col_next   = right_col;
                        value_next = right_value;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg   <= row_next;
        col_reg   <= col_next;
        value_reg <= value_next;
    end

    assign valid_o = valid_reg;
    assign row_o   = row_reg;
    assign col_o   = col_reg;
    assign value_o = value_reg;
    assign lt_o    = lt_reg;
    assign eq_o    = eq_reg;

endmodule

FILE: rtl/sparse_matrix_entry_store_top.sv
// Channel   Ports                      Word
// input     s_valid s_ready s_word     func, row_index, col_index, write_value
// result    m_valid m_ready m_word     read_value, status
//
// In the accept cycle every cell latches the key compare; in the apply state
// that follows, the chain shifts (insert/delete) and the result is loaded.
// A new word is taken only once the previous one has been applied.
// If the result register is still full, the apply cycle waits; the store is
// not touched until it goes. Reset (aresetn, sync, active low) empties the
// store through the cell valid bits.
// Depends on smes_pkg, smes_cell and sparse_matrix_entry_store_top_macros.svh.
`include "sparse_matrix_entry_store_top_macros.svh"

module sparse_matrix_entry_store_top import smes_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int INDEX_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  smes_in_t  s_word,
    output logic      m_valid,
    input  logic      m_ready,
    output smes_out_t m_word
);

    state_t                state_reg, state_next;
    smes_in_t              item_reg;
    smes_out_t             m_word_reg, m_word_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  s_accept;
    logic                  out_free;
    cell_ctrl_t            ctrl;
    smes_in_t              key_src;
    logic [31:0]           row_wide, col_wide;
    logic [INDEX_BITS-1:0] key_row, key_col;

    logic [CAPACITY-1:0]   valid_vec, lt_vec, eq_vec;
    logic [INDEX_BITS-1:0] row_arr   [CAPACITY];
    logic [INDEX_BITS-1:0] col_arr   [CAPACITY];
    logic [31:0]           value_arr [CAPACITY];

    logic        hit, empty, full, write_zero;
    logic [31:0] hit_value;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Compare uses the incoming word, apply uses the held one.
    assign key_src  = (state_reg == ST_IDLE) ? s_word : item_reg;
    assign row_wide = 32'(key_src.row_index);
    assign col_wide = 32'(key_src.col_index);
    assign key_row  = row_wide[INDEX_BITS-1:0];
    assign key_col  = col_wide[INDEX_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                  l_valid, l_lt, r_valid;
            logic [INDEX_BITS-1:0] l_row, l_col, r_row, r_col;
            logic [31:0]           l_value, r_value;

            if (gi == 0) begin : g_head
                assign l_valid = 1'b0;
                assign l_lt    = 1'b1;
                assign l_row   = '0;
                assign l_col   = '0;
                assign l_value = '0;
            end else begin : g_link_l
                assign l_valid = valid_vec[gi-1];
                assign l_lt    = lt_vec[gi-1];
                assign l_row   = row_arr[gi-1];
                assign l_col   = col_arr[gi-1];
                assign l_value = value_arr[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                assign r_valid = 1'b0;
                assign r_row   = '0;
                assign r_col   = '0;
                assign r_value = '0;
            end else begin : g_link_r
                assign r_valid = valid_vec[gi+1];
                assign r_row   = row_arr[gi+1];
                assign r_col   = col_arr[gi+1];
                assign r_value = value_arr[gi+1];
            end

            smes_cell #(
                .INDEX_BITS (INDEX_BITS)
            ) u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ctrl),
                .key_row     (key_row),
                .key_col     (key_col),
                .new_value   (item_reg.write_value),
                .left_valid  (l_valid),
                .left_row    (l_row),
                .left_col    (l_col),
                .left_value  (l_value),
                .left_lt     (l_lt),
                .right_valid (r_valid),
                .right_row   (r_row),
                .right_col   (r_col),
                .right_value (r_value),
                .valid_o     (valid_vec[gi]),
                .row_o       (row_arr[gi]),
                .col_o       (col_arr[gi]),
                .value_o     (value_arr[gi]),
                .lt_o        (lt_vec[gi]),
                .eq_o        (eq_vec[gi])
            );
        end
    endgenerate

    // At most one cell matches, so an OR over masked values selects it.
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_value = hit_value | (eq_vec[i] ? value_arr[i] : 32'd0);
        end
    end

    assign hit        = |eq_vec;
    assign empty      = !valid_vec[0];
    assign full       = valid_vec[CAPACITY-1];
    assign write_zero = (item_reg.write_value == 32'd0);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        ctrl.cmp_en   = s_accept;
        ctrl.apply_en = 1'b0;
        ctrl.op       = OP_NONE;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                m_word_next.read_value = '0;
                m_word_next.status     = STATUS_OK;
                if (item_reg.func == FUNC_READ) begin
                    if (empty) begin
                        m_word_next.status = STATUS_EMPTY;
                    end else if (hit) begin
                        m_word_next.read_value = hit_value;
                    end
                end else if (hit) begin
                    ctrl.op = write_zero ? OP_DELETE : OP_UPDATE;
                end else if (!write_zero) begin
                    if (full) begin
                        m_word_next.status = STATUS_FULL;
                    end else begin
                        ctrl.op = OP_INSERT;
                    end
                end

                if (out_free) begin
                    ctrl.apply_en = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end else begin
                    m_word_next = m_word_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        if (s_accept) begin
            item_reg <= s_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // Valid entries always form a prefix of the chain.
    `SMES_ASSERT_NOW(a_valid_prefix, aclk, aresetn, 1'b1, ((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
    // Sorted unique keys: at most one cell can match.
    `SMES_ASSERT_NOW(a_single_hit, aclk, aresetn, 1'b1, $onehot0(eq_vec))
    // An accepted word always goes to the apply cycle.
    `SMES_ASSERT_NEXT(a_accept_apply, aclk, aresetn, s_accept, state_reg == ST_APPLY)

endmodule

FILE: bench/sparse_matrix_entry_store_checker.sv
// Scoreboard for the sparse matrix entry store: watches both channels,
// keeps its own sorted copy of the store and compares every result word.
// Depends on smes_pkg for the word types and the function/status codes.
`timescale 1ns / 100ps

module sparse_matrix_entry_store_checker import smes_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  smes_in_t  s_word,
    input  logic      m_valid,
    input  logic      m_ready,
    input  smes_out_t m_word,
    output int        fail_count,
    output int        pending_count,
    output int        results_checked,
    output int        read_hits,
    output int        removals,
    output int        empty_reads,
    output int        full_drops
);

    // Shadow store, valid entries in 0..entry_fill-1, row-major order.
    logic [15:0] entry_row [CAPACITY];
    logic [15:0] entry_col [CAPACITY];
    logic [31:0] entry_val [CAPACITY];
    int          entry_fill;

    smes_out_t   predicted_replies [$];

    initial begin
        fail_count      = 0;
        pending_count   = 0;
        results_checked = 0;
        read_hits       = 0;
        removals        = 0;
        empty_reads     = 0;
        full_drops      = 0;
        entry_fill      = 0;
    end

    // Applies one input word to the shadow store and returns its reply.
    function automatic smes_out_t store_apply(smes_in_t w);
        logic [31:0] key;
        int          pos;
        int          k;
        bit          hit;
        smes_out_t   r;
        key          = {w.row_index, w.col_index};
        r.read_value = '0;
        r.status     = STATUS_OK;
        pos          = 0;
        while (pos < entry_fill && {entry_row[pos], entry_col[pos]} < key)
            pos++;
        hit = (pos < entry_fill) && ({entry_row[pos], entry_col[pos]} == key);

        if (w.func == FUNC_READ) begin
            if (entry_fill == 0) begin
                r.status = STATUS_EMPTY;
                empty_reads++;
            end else if (hit) begin
                r.read_value = entry_val[pos];
                read_hits++;
            end
        end else if (hit) begin
            if (w.write_value == '0) begin
                for (k = pos; k + 1 < entry_fill; k++) begin
                    entry_row[k] = entry_row[k + 1];
                    entry_col[k] = entry_col[k + 1];
                    entry_val[k] = entry_val[k + 1];
                end
                entry_fill--;
                removals++;
            end else begin
                entry_val[pos] = w.write_value;
            end
        end else if (w.write_value != '0) begin
            if (entry_fill >= CAPACITY) begin
                r.status = STATUS_FULL;
                full_drops++;
            end else begin
                for (k = entry_fill; k > pos; k--) begin
                    entry_row[k] = entry_row[k - 1];
                    entry_col[k] = entry_col[k - 1];
                    entry_val[k] = entry_val[k - 1];
                end
                entry_row[pos] = w.row_index;
                entry_col[pos] = w.col_index;
                entry_val[pos] = w.write_value;
                entry_fill++;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        smes_out_t want;
        if (!aresetn) begin
            predicted_replies.delete();
            entry_fill = 0;
        end else begin
            // Result side first: a word accepted this edge cannot answer yet.
            if (m_valid && m_ready) begin
                if (predicted_replies.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result word with nothing outstanding: value %h status %0d",
                                 $realtime, m_word.read_value, m_word.status);
                    fail_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    results_checked++;
                    if (m_word.read_value !== want.read_value ||
                        m_word.status !== want.status) begin
                        if (fail_count < 10)
                            $display("%0t: mismatch: value %h (want %h) status %0d (want %0d)",
                                     $realtime, m_word.read_value, want.read_value,
                                     m_word.status, want.status);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                predicted_replies.push_back(store_apply(s_word));
        end
        pending_count <= predicted_replies.size();
    end

endmodule

FILE: bench/sparse_matrix_entry_store_top_tb.sv
// Testbench top for sparse_matrix_entry_store_top: clock, reset, stimulus,
// receiver stalls and the verdict. Checking lives in the checker module.
// Depends on smes_pkg, the store RTL and sparse_matrix_entry_store_checker.
`timescale 1ns / 100ps

module sparse_matrix_entry_store_top_tb import smes_pkg::*;;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    smes_in_t  s_word;
    logic      m_valid;
    logic      m_ready = 1'b1;
    smes_out_t m_word;

    int fail_count;
    int pending_count;
    int results_checked;
    int read_hits;
    int removals;
    int empty_reads;
    int full_drops;

    int words_sent         = 0;
    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;

    sparse_matrix_entry_store_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    sparse_matrix_entry_store_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_word          (s_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_word          (m_word),
        .fail_count      (fail_count),
        .pending_count   (pending_count),
        .results_checked (results_checked),
        .read_hits       (read_hits),
        .removals        (removals),
        .empty_reads     (empty_reads),
        .full_drops      (full_drops)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d result words outstanding", pending_count);
        $display("TEST FAILED");
        $finish;
    end

    // Offers one word, with optional idle cycles ahead of it, and returns at the
    // edge where it is taken.
    task automatic put_word(input logic f, input logic [15:0] r, input logic [15:0] c,
                            input logic [31:0] v);
        smes_in_t w;
        w.func        = f;
        w.row_index   = r;
        w.col_index   = c;
        w.write_value = v;
        while ($urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        words_sent++;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'hffff_ffff;
            default: v = $urandom;
        endcase
        if (v == '0)
            v = 32'd1;
        return v;
    endfunction

    // One pass over a pool of keys: fill (the big pool overflows the store),
    // churn with some random-key noise, then remove every pool key so the
    // store ends empty and the closing reads hit the empty case.
    task automatic run_epoch(input bit big);
        logic [15:0] row_set  [4];
        logic [15:0] pool_row [96];
        logic [15:0] pool_col [96];
        int          pool_n;
        int          i;
        int          j;
        int          roll;
        pool_n = big ? 96 : $urandom_range(8, 24);
        for (i = 0; i < 4; i++)
            row_set[i] = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(3));
        for (i = 0; i < pool_n; i++) begin
            pool_row[i] = row_set[$urandom_range(3)];
            pool_col[i] = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15));
        end

        repeat (2 * pool_n) begin
            j    = $urandom_range(pool_n - 1);
            roll = $urandom_range(99);
            if (roll < 75)
                put_word(FUNC_WRITE, pool_row[j], pool_col[j], pick_value());
            else if (roll < 85)
                put_word(FUNC_WRITE, pool_row[j], pool_col[j], '0);
            else
                put_word(FUNC_READ, pool_row[j], pool_col[j], $urandom);
        end

        repeat (pool_n) begin
            j    = $urandom_range(pool_n - 1);
            roll = $urandom_range(99);
            if (roll < 35)
                put_word(FUNC_READ, pool_row[j], pool_col[j], $urandom);
            else if (roll < 60)
                put_word(FUNC_WRITE, pool_row[j], pool_col[j], pick_value());
            else if (roll < 85)
                put_word(FUNC_WRITE, pool_row[j], pool_col[j], '0);
            else if (roll < 93)
                put_word(FUNC_READ, 16'($urandom), 16'($urandom), $urandom);
            else
                put_word(FUNC_WRITE, 16'($urandom), 16'($urandom), '0);
        end

        for (i = 0; i < pool_n; i++) begin
            put_word(FUNC_WRITE, pool_row[i], pool_col[i], '0);
            if ($urandom_range(4) == 0) begin
                j = $urandom_range(pool_n - 1);
                put_word(FUNC_READ, pool_row[j], pool_col[j], $urandom);
            end
        end
        repeat (2) begin
            j = $urandom_range(pool_n - 1);
            put_word(FUNC_READ, pool_row[j], pool_col[j], $urandom);
        end
    endtask

    initial begin
        int epoch;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_word  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty store, index and value extremes, unsigned ordering,
        // hit, miss, update, removal and zero writes that change nothing.
        put_word(FUNC_READ,  16'h0000, 16'h0000, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h0005, 16'h0005, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h0000, 16'h0000, 32'h7fff_ffff);
        put_word(FUNC_WRITE, 16'hffff, 16'hffff, 32'h8000_0000);
        put_word(FUNC_WRITE, 16'h0000, 16'hffff, 32'hffff_ffff);
        put_word(FUNC_WRITE, 16'hffff, 16'h0000, 32'h0000_0001);
        put_word(FUNC_WRITE, 16'h8000, 16'h0001, 32'h5555_5555);
        put_word(FUNC_WRITE, 16'h7fff, 16'hffff, 32'haaaa_aaaa);
        put_word(FUNC_READ,  16'hffff, 16'hffff, 32'hffff_ffff);
        put_word(FUNC_READ,  16'h0000, 16'h0000, 32'h0000_0000);
        put_word(FUNC_READ,  16'h0001, 16'h0001, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h8000, 16'h0001, 32'h1234_5678);
        put_word(FUNC_READ,  16'h8000, 16'h0001, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h0001, 16'h0001, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h0000, 16'hffff, 32'h0000_0000);
        put_word(FUNC_READ,  16'h0000, 16'hffff, 32'h0000_0000);
        put_word(FUNC_READ,  16'hffff, 16'h0000, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h0000, 16'h0000, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'hffff, 16'hffff, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'hffff, 16'h0000, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h8000, 16'h0001, 32'h0000_0000);
        put_word(FUNC_WRITE, 16'h7fff, 16'hffff, 32'h0000_0000);
        put_word(FUNC_READ,  16'h7fff, 16'hffff, 32'h0000_0000);

        // Random epochs, cycling through the idle/stall mixes; small pools
        // near the end keep the word count close to the target.
        epoch = 0;
        while (words_sent < 1700) begin
            case (epoch % 4)
                0: begin sender_gap_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_gap_pct = 47; receiver_stall_pct = 0;  end
                2: begin sender_gap_pct = 0;  receiver_stall_pct = 47; end
                default: begin sender_gap_pct = 6; receiver_stall_pct = 6; end
            endcase
            run_epoch(epoch == 0 || ($urandom_range(2) != 0 && words_sent < 1300));
            epoch++;
        end
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("Sent %0d words in %0d epochs; %0d results checked", words_sent, epoch,
                 results_checked);
        $display("Read hits %0d, removals %0d, empty-store reads %0d, full-store drops %0d",
                 read_hits, removals, empty_reads, full_drops);
        if (fail_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/smes_pkg.sv
rtl/smes_cell.sv
rtl/sparse_matrix_entry_store_top.sv
bench/sparse_matrix_entry_store_checker.sv
bench/sparse_matrix_entry_store_top_tb.sv
